### hw/rtl/mqsb_pkg.sv
package mqsb_pkg;

    localparam int NUM_QUEUES_DEF = 4;
    localparam int NUM_SLOTS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [1:0]         queue_id;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] pop_value;
    } t_out_item;

    // The queue number is already reduced, so it is below both 4 and the queue count.
    typedef struct packed {
        logic               is_pop;
        logic [1:0]         queue;
        logic signed [31:0] value;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCESS,
        S_FINISH
    } t_state;

endpackage

### hw/rtl/multi_queue_shared_buffer.sv
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_ready  i_in_item   (operation, queue_id, push_value)
// out       output     o_out_valid / i_out_ready o_out_item (status, pop_value)
//
// Each item goes through the back end in order: a queue table read, the slot and link
// access, and the pointer update that loads the result register.
// An accepted item is registered in the two-entry command queue of the front end before the back end sees it.
// Reset is synchronous and needs no clearing pass; a fill mark stands in for the slot chain.
// The front end keeps accepting items while a result waits to be taken, until its queue fills.
module multi_queue_shared_buffer #(
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
    parameter int NUM_SLOTS  = mqsb_pkg::NUM_SLOTS_DEF,
    parameter int DATA_WIDTH = mqsb_pkg::DATA_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mqsb_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mqsb_pkg::t_out_item o_out_item
);

    logic           cmd_valid;
    logic           cmd_ready;
    mqsb_pkg::t_cmd cmd;

    mqsb_front #(.NUM_QUEUES(NUM_QUEUES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    mqsb_back #(
        .NUM_QUEUES (NUM_QUEUES),
        .NUM_SLOTS  (NUM_SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### hw/rtl/mqsb_ram.sv
module mqsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mqsb_front.sv
module mqsb_front #(
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mqsb_pkg::t_in_item i_in_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output mqsb_pkg::t_cmd    o_cmd
);

    mqsb_pkg::t_cmd r_entry [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           n_wr_ptr;
    logic           n_rd_ptr;
    logic [1:0]     n_count;
    logic           push_en;
    logic           pop_en;
    logic [1:0]     queue_red;
    mqsb_pkg::t_cmd new_cmd;

    always_comb begin
        queue_red = i_in_item.queue_id;
        for (int k = 0; k < 3; k++) begin
            if (int'(queue_red) >= NUM_QUEUES) begin
                queue_red = queue_red - 2'(NUM_QUEUES);
            end
        end
        new_cmd.is_pop = (i_in_item.operation == mqsb_pkg::OP_POP);
        new_cmd.queue  = queue_red;
        new_cmd.value  = i_in_item.push_value;
    end

    assign o_in_ready  = (r_count != 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_entry[r_rd_ptr];
    assign push_en     = i_in_valid && o_in_ready;
    assign pop_en      = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = push_en ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop_en ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push_en && !pop_en) begin
            n_count = r_count + 2'd1;
        end else if (pop_en && !push_en) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_entry[r_wr_ptr] <= new_cmd;
        end
    end

endmodule

### hw/rtl/mqsb_back.sv
module mqsb_back #(
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
    parameter int NUM_SLOTS  = mqsb_pkg::NUM_SLOTS_DEF,
    parameter int DATA_WIDTH = mqsb_pkg::DATA_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  mqsb_pkg::t_cmd      i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mqsb_pkg::t_out_item o_out_item
);

    localparam int PW = $clog2(NUM_SLOTS + 1);
    localparam int SW = $clog2(NUM_SLOTS);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [PW-1:0] NULL_PTR = PW'(NUM_SLOTS);

    mqsb_pkg::t_state    r_state;
    mqsb_pkg::t_state    n_state;
    logic                r_is_pop;
    logic [QW-1:0]       r_queue;
    logic [DATA_WIDTH-1:0] r_value;
    logic [PW-1:0]       r_head;
    logic [PW-1:0]       r_tail;
    logic                r_ok;
    logic [PW-1:0]       r_free_head;
    logic [PW-1:0]       n_free_head;
    logic [PW-1:0]       r_fill;
    logic [PW-1:0]       n_fill;
    logic [NUM_QUEUES-1:0] r_qvalid;
    logic [NUM_QUEUES-1:0] n_qvalid;
    logic                r_out_valid;
    logic                n_out_valid;
    mqsb_pkg::t_out_item r_out_item;
    mqsb_pkg::t_out_item n_out_item;

    logic                start;
    logic [PW-1:0]       q_head;
    logic [PW-1:0]       q_tail;
    logic                access_ok;
    logic                fresh;
    logic [PW-1:0]       link_next;

    logic                qram_we;
    logic [2*PW-1:0]     qram_wdata;
    logic [2*PW-1:0]     qram_rdata;
    logic                link_we;
    logic [SW-1:0]       link_waddr;
    logic [PW-1:0]       link_wdata;
    logic [SW-1:0]       link_raddr;
    logic [PW-1:0]       link_rdata;
    logic                data_we;
    logic [DATA_WIDTH-1:0] data_rdata;

    mqsb_ram #(.WIDTH(2 * PW), .DEPTH(NUM_QUEUES)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (qram_we),
        .i_waddr (r_queue),
        .i_wdata (qram_wdata),
        .i_raddr (QW'(i_cmd.queue)),
        .o_rdata (qram_rdata)
    );

    mqsb_ram #(.WIDTH(PW), .DEPTH(NUM_SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    mqsb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_SLOTS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (SW'(r_free_head)),
        .i_wdata (r_value),
        .i_raddr (SW'(q_head)),
        .o_rdata (data_rdata)
    );

    assign o_cmd_ready = (r_state == mqsb_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign start       = i_cmd_valid && o_cmd_ready;
    assign q_head      = r_qvalid[r_queue] ? qram_rdata[2*PW-1:PW] : NULL_PTR;
    assign q_tail      = qram_rdata[PW-1:0];
    assign access_ok   = r_is_pop ? (q_head < NULL_PTR) : (r_free_head < NULL_PTR);
    assign link_raddr  = SW'(r_is_pop ? q_head : r_free_head);

    // Slots at or above the fill mark have no stored link; their next free slot is the following index.
    assign fresh     = (r_free_head >= r_fill);
    assign link_next = fresh ? (r_free_head + PW'(1)) : link_rdata;

    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_fill      = r_fill;
        n_qvalid    = r_qvalid;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        qram_we     = 1'b0;
        qram_wdata  = {r_head, r_tail};
        link_we     = 1'b0;
        link_waddr  = SW'(r_tail);
        link_wdata  = r_free_head;
        data_we     = 1'b0;
        case (r_state)
            mqsb_pkg::S_IDLE: begin
                if (start) begin
                    n_state = mqsb_pkg::S_ACCESS;
                end
            end
            mqsb_pkg::S_ACCESS: begin
                if (!r_is_pop && access_ok) begin
                    data_we = 1'b1;
                    if ((q_head < NULL_PTR) && (q_tail < NULL_PTR)) begin
                        link_we    = 1'b1;
                        link_waddr = SW'(q_tail);
                        link_wdata = r_free_head;
                    end
                end
                n_state = mqsb_pkg::S_FINISH;
            end
            mqsb_pkg::S_FINISH: begin
                n_out_valid          = 1'b1;
                n_out_item.status    = mqsb_pkg::STATUS_DONE;
                n_out_item.pop_value = '0;
                if (!r_ok) begin
                    n_out_item.status = r_is_pop ? mqsb_pkg::STATUS_EMPTY
                                                 : mqsb_pkg::STATUS_FULL;
                end else if (r_is_pop) begin
                    n_out_item.pop_value = 32'($signed(data_rdata));
                    link_we     = 1'b1;
                    link_waddr  = SW'(r_head);
                    link_wdata  = r_free_head;
                    n_free_head = r_head;
                    qram_we     = 1'b1;
                    qram_wdata  = {link_rdata, r_tail};
                    n_qvalid[r_queue] = 1'b1;
                end else begin
                    link_we     = 1'b1;
                    link_waddr  = SW'(r_free_head);
                    link_wdata  = NULL_PTR;
                    n_free_head = link_next;
                    if (fresh) begin
                        n_fill = r_free_head + PW'(1);
                    end
                    qram_we    = 1'b1;
                    qram_wdata = {((r_head < NULL_PTR) ? r_head : r_free_head), r_free_head};
                    n_qvalid[r_queue] = 1'b1;
                end
                n_state = mqsb_pkg::S_IDLE;
            end
            default: begin
                n_state = mqsb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mqsb_pkg::S_IDLE;
            r_free_head <= '0;
            r_fill      <= '0;
            r_qvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_fill      <= n_fill;
            r_qvalid    <= n_qvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        if (start) begin
            r_is_pop <= i_cmd.is_pop;
            r_queue  <= QW'(i_cmd.queue);
            r_value  <= DATA_WIDTH'($unsigned(i_cmd.value));
        end
        if (r_state == mqsb_pkg::S_ACCESS) begin
            r_head <= q_head;
            r_tail <= q_tail;
            r_ok   <= access_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
